### src/scp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and state encoding for the segment chaining block.
package scp_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int COORD_W      = 16;
    localparam int SEG_W        = 4 * COORD_W;
    localparam int HALF_W       = SEG_W / 2;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int SQ_W         = 2 * COORD_W;
    localparam int DIST_W       = SQ_W + 1;
    localparam int LIMIT_W      = 17;
    localparam int LIM_SQ_W     = 2 * LIMIT_W;
    localparam int MIN_CHAIN    = 4;

    localparam logic [LIMIT_W-1:0] JOIN_LIMIT_RESET = LIMIT_W'(10000);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_FETCH0,
        ST_CUR0,
        ST_SCAN,
        ST_DRAIN,
        ST_SWAP,
        ST_PUT,
        ST_RD,
        ST_LD,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic             vld;
        logic             first;
        logic [IDX_W-1:0] idx;
    } tag_t;

    typedef struct packed {
        logic              vld;
        logic              first;
        logic [IDX_W-1:0]  idx;
        logic              kend;
        logic [DIST_W-1:0] dsq;
        logic [SEG_W-1:0]  seg;
    } cand_t;

endpackage

### src/scp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
module scp_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### src/scp_dist.sv
`timescale 1ns / 1ps
// Pipelined squared-distance unit: both endpoints of one stored segment per cycle.
module scp_dist (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  scp_pkg::tag_t                         tag,
    input  logic [scp_pkg::SEG_W-1:0]             rdata,
    input  logic signed [scp_pkg::COORD_W-1:0]    px,
    input  logic signed [scp_pkg::COORD_W-1:0]    py,
    output scp_pkg::cand_t                        cand,
    output logic                                  busy
);

    scp_pkg::tag_t t1_reg, t2_reg, t3_reg, t4_reg;
    scp_pkg::cand_t cand_reg;

    logic [scp_pkg::SEG_W-1:0] seg2_reg, seg3_reg, seg4_reg;
    logic signed [scp_pkg::DIFF_W-1:0] dx0_reg, dy0_reg, dx1_reg, dy1_reg;
    logic [scp_pkg::SQ_W-1:0] sx0_reg, sy0_reg, sx1_reg, sy1_reg;
    logic [scp_pkg::DIST_W-1:0] d0_reg, d1_reg;

    logic signed [scp_pkg::DIFF_W-1:0] dx0, dy0, dx1, dy1;
    logic signed [scp_pkg::PROD_W-1:0] px0, py0, px1, py1;
    logic kend;

    // stage 1: coordinate differences against current chain end
    assign dx0 = $signed({px[scp_pkg::COORD_W-1], px})
               - $signed({rdata[scp_pkg::COORD_W-1], rdata[scp_pkg::COORD_W-1:0]});
    assign dy0 = $signed({py[scp_pkg::COORD_W-1], py})
               - $signed({rdata[2*scp_pkg::COORD_W-1],
                          rdata[2*scp_pkg::COORD_W-1:scp_pkg::COORD_W]});
    assign dx1 = $signed({px[scp_pkg::COORD_W-1], px})
               - $signed({rdata[3*scp_pkg::COORD_W-1],
                          rdata[3*scp_pkg::COORD_W-1:2*scp_pkg::COORD_W]});
    assign dy1 = $signed({py[scp_pkg::COORD_W-1], py})
               - $signed({rdata[4*scp_pkg::COORD_W-1],
                          rdata[4*scp_pkg::COORD_W-1:3*scp_pkg::COORD_W]});

    // stage 2: squares
    assign px0 = dx0_reg * dx0_reg;
    assign py0 = dy0_reg * dy0_reg;
    assign px1 = dx1_reg * dx1_reg;
    assign py1 = dy1_reg * dy1_reg;

    // stage 4: nearer endpoint, ties keep the first endpoint
    assign kend = d1_reg < d0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg   <= '0;
            t2_reg   <= '0;
            t3_reg   <= '0;
            t4_reg   <= '0;
            cand_reg <= '0;
        end
        else
        begin
            t1_reg         <= tag;
            t2_reg         <= t1_reg;
            t3_reg         <= t2_reg;
            t4_reg         <= t3_reg;
            cand_reg.vld   <= t4_reg.vld;
            cand_reg.first <= t4_reg.first;
            cand_reg.idx   <= t4_reg.idx;
            cand_reg.kend  <= kend;
            cand_reg.dsq   <= kend ? d1_reg : d0_reg;
            cand_reg.seg   <= seg4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx0_reg  <= dx0;
        dy0_reg  <= dy0;
        dx1_reg  <= dx1;
        dy1_reg  <= dy1;
        seg2_reg <= rdata;

        sx0_reg  <= px0[scp_pkg::SQ_W-1:0];
        sy0_reg  <= py0[scp_pkg::SQ_W-1:0];
        sx1_reg  <= px1[scp_pkg::SQ_W-1:0];
        sy1_reg  <= py1[scp_pkg::SQ_W-1:0];
        seg3_reg <= seg2_reg;

        d0_reg   <= {1'b0, sx0_reg} + {1'b0, sy0_reg};
        d1_reg   <= {1'b0, sx1_reg} + {1'b0, sy1_reg};
        seg4_reg <= seg3_reg;
    end

    assign cand = cand_reg;
    assign busy = t1_reg.vld | t2_reg.vld | t3_reg.vld | t4_reg.vld | cand_reg.vld;

endmodule

### src/segment_chain_ordering.sv
`timescale 1ns / 1ps
// Top level: segment store, greedy nearest-endpoint chaining and result streaming.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata: start_x, start_y, end_x, end_y; tlast: last_in
//  m_axis   | out       | tdata: out_start_x..out_end_y; tlast: last_out;
//           |           | tuser: overflow
//  cfg      | in        | data: join_limit, taken only while loading
//
// Loading takes one item per cycle. For n >= 4 segments, ST_FETCH0 and ST_CUR0 fetch the first
// segment; chaining position i then costs (n-1-i) store reads through the distance
// pipeline, a wait in ST_DRAIN until that pipeline is empty, and the write-backs in
// ST_SWAP and ST_PUT.
// Each result then passes through ST_RD, ST_LD and ST_SEND, and waits there on m_tready. No input item is taken
// from the last item of a list until the last result has left. Reset is
// asynchronous; the store needs no clearing pass.
module segment_chain_ordering (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [scp_pkg::SEG_W-1:0]        s_tdata,   // start_x, start_y, end_x, end_y
    input  logic                             s_tlast,   // last_in
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [scp_pkg::SEG_W-1:0]        m_tdata,   // out_start_x, out_start_y,
                                                        // out_end_x, out_end_y
    output logic                             m_tlast,   // last_out
    output logic [0:0]                       m_tuser,   // overflow
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [scp_pkg::LIMIT_W-1:0]      cfg_data   // join_limit
);

    scp_pkg::state_t state_reg, state_next;

    logic [scp_pkg::CNT_W-1:0]    count_reg;
    logic                         dropped_reg;
    logic [scp_pkg::IDX_W-1:0]    i_reg, j_reg;
    logic [scp_pkg::LIMIT_W-1:0]  limit_reg;
    logic [scp_pkg::LIM_SQ_W-1:0] lim_init_reg, lim_reg;
    logic [scp_pkg::IDX_W-1:0]    best_reg;
    logic                         bend_reg;
    logic [scp_pkg::SEG_W-1:0]    first_seg_reg, best_seg_reg, cur_reg;
    logic [scp_pkg::SEG_W-1:0]    out_data_reg;
    logic                         out_last_reg, out_user_reg, out_valid_reg;

    logic                         ram_we;
    logic [scp_pkg::IDX_W-1:0]    ram_waddr, ram_raddr;
    logic [scp_pkg::SEG_W-1:0]    ram_wdata, ram_rdata;
    scp_pkg::tag_t                tag;
    scp_pkg::cand_t               cand;
    logic                         busy;

    logic                         in_acc, has_room, scan_end, more_pos, cand_hit;
    logic [scp_pkg::CNT_W-1:0]    n_final, last_idx;
    logic [scp_pkg::IDX_W-1:0]    i_next1;
    logic [scp_pkg::SEG_W-1:0]    new_seg;

    scp_ram #(
        .DEPTH  (scp_pkg::MAX_SEGMENTS),
        .DATA_W (scp_pkg::SEG_W),
        .ADDR_W (scp_pkg::IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    scp_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .tag   (tag),
        .rdata (ram_rdata),
        .px    (cur_reg[3*scp_pkg::COORD_W-1:2*scp_pkg::COORD_W]),
        .py    (cur_reg[4*scp_pkg::COORD_W-1:3*scp_pkg::COORD_W]),
        .cand  (cand),
        .busy  (busy)
    );

    assign in_acc   = s_tvalid & s_tready;
    assign has_room = count_reg < scp_pkg::CNT_W'(scp_pkg::MAX_SEGMENTS);
    assign n_final  = has_room ? count_reg + scp_pkg::CNT_W'(1) : count_reg;
    assign last_idx = count_reg - scp_pkg::CNT_W'(1);
    assign i_next1  = i_reg + scp_pkg::IDX_W'(1);
    assign scan_end = scp_pkg::CNT_W'(j_reg) == last_idx;
    assign more_pos = (scp_pkg::CNT_W'(i_reg) + scp_pkg::CNT_W'(2)) < count_reg;
    assign new_seg  = bend_reg
                    ? {best_seg_reg[scp_pkg::HALF_W-1:0],
                       best_seg_reg[scp_pkg::SEG_W-1:scp_pkg::HALF_W]}
                    : best_seg_reg;
    assign cand_hit = scp_pkg::LIM_SQ_W'(cand.dsq) < lim_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scp_pkg::ST_LOAD:
            begin
                if (in_acc && s_tlast)
                begin
                    if (n_final < scp_pkg::CNT_W'(scp_pkg::MIN_CHAIN))
                    begin
                        state_next = scp_pkg::ST_RD;
                    end
                    else
                    begin
                        state_next = scp_pkg::ST_FETCH0;
                    end
                end
            end
            scp_pkg::ST_FETCH0: state_next = scp_pkg::ST_CUR0;
            scp_pkg::ST_CUR0:   state_next = scp_pkg::ST_SCAN;
            scp_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = scp_pkg::ST_DRAIN;
                end
            end
            scp_pkg::ST_DRAIN:
            begin
                if (!busy)
                begin
                    state_next = scp_pkg::ST_SWAP;
                end
            end
            scp_pkg::ST_SWAP:   state_next = scp_pkg::ST_PUT;
            scp_pkg::ST_PUT:
            begin
                state_next = more_pos ? scp_pkg::ST_SCAN : scp_pkg::ST_RD;
            end
            scp_pkg::ST_RD:     state_next = scp_pkg::ST_LD;
            scp_pkg::ST_LD:     state_next = scp_pkg::ST_SEND;
            scp_pkg::ST_SEND:
            begin
                if (m_tready)
                begin
                    state_next = out_last_reg ? scp_pkg::ST_LOAD : scp_pkg::ST_RD;
                end
            end
            default:            state_next = scp_pkg::ST_LOAD;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = count_reg[scp_pkg::IDX_W-1:0];
        ram_wdata = s_tdata;
        ram_raddr = j_reg;
        tag       = '0;
        case (state_reg)
            scp_pkg::ST_LOAD:
            begin
                s_tready = 1'b1;
                ram_we   = in_acc & has_room;
            end
            scp_pkg::ST_FETCH0:
            begin
                ram_raddr = '0;
            end
            scp_pkg::ST_SCAN:
            begin
                tag.vld   = 1'b1;
                tag.first = j_reg == i_next1;
                tag.idx   = j_reg;
            end
            scp_pkg::ST_SWAP:
            begin
                ram_we    = best_reg != i_next1;
                ram_waddr = best_reg;
                ram_wdata = first_seg_reg;
            end
            scp_pkg::ST_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_next1;
                ram_wdata = new_seg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scp_pkg::ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            limit_reg     <= scp_pkg::JOIN_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            case (state_reg)
                scp_pkg::ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (has_room)
                        begin
                            count_reg <= count_reg + scp_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                        j_reg <= '0;
                    end
                end
                scp_pkg::ST_CUR0:
                begin
                    i_reg <= '0;
                    j_reg <= scp_pkg::IDX_W'(1);
                end
                scp_pkg::ST_SCAN:
                begin
                    j_reg <= j_reg + scp_pkg::IDX_W'(1);
                end
                scp_pkg::ST_PUT:
                begin
                    i_reg <= i_next1;
                    j_reg <= more_pos ? i_reg + scp_pkg::IDX_W'(2) : '0;
                end
                scp_pkg::ST_LD:
                begin
                    out_valid_reg <= 1'b1;
                end
                scp_pkg::ST_SEND:
                begin
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            count_reg   <= '0;
                            dropped_reg <= 1'b0;
                        end
                        else
                        begin
                            j_reg <= j_reg + scp_pkg::IDX_W'(1);
                        end
                    end
                end
                default:
                begin
                    out_valid_reg <= out_valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        lim_init_reg <= scp_pkg::LIM_SQ_W'(limit_reg) * scp_pkg::LIM_SQ_W'(limit_reg);

        if (state_reg == scp_pkg::ST_CUR0 || state_reg == scp_pkg::ST_PUT)
        begin
            lim_reg <= lim_init_reg;
        end
        else if (cand.vld && cand_hit)
        begin
            lim_reg <= scp_pkg::LIM_SQ_W'(cand.dsq);
        end

        if (cand.vld)
        begin
            if (cand_hit)
            begin
                best_reg     <= cand.idx;
                bend_reg     <= cand.kend;
                best_seg_reg <= cand.seg;
            end
            else if (cand.first)
            begin
                best_reg     <= cand.idx;
                bend_reg     <= 1'b0;
                best_seg_reg <= cand.seg;
            end
            if (cand.first)
            begin
                first_seg_reg <= cand.seg;
            end
        end

        if (state_reg == scp_pkg::ST_CUR0)
        begin
            cur_reg <= ram_rdata;
        end
        else if (state_reg == scp_pkg::ST_PUT)
        begin
            cur_reg <= new_seg;
        end

        if (state_reg == scp_pkg::ST_LD)
        begin
            out_data_reg <= ram_rdata;
            out_last_reg <= scp_pkg::CNT_W'(j_reg) == last_idx;
            out_user_reg <= dropped_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_user_reg;
    assign cfg_ready  = state_reg == scp_pkg::ST_LOAD;

`ifndef SYNTH
    a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= scp_pkg::CNT_W'(scp_pkg::MAX_SEGMENTS))
        else $error("segment count beyond capacity");

    a_best_after_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == scp_pkg::ST_SWAP |-> best_reg >= i_next1)
        else $error("chosen segment lies before the next position");

    a_cand_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        cand.vld |-> (state_reg == scp_pkg::ST_SCAN || state_reg == scp_pkg::ST_DRAIN))
        else $error("distance result outside the search phase");

    a_drained_swap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == scp_pkg::ST_SWAP |-> !busy)
        else $error("write-back started with distance pipeline busy");
`endif

endmodule

### dv/chain_order_checker.sv
`timescale 1ns / 1ps
// Checker: follows segment lists and join_limit writes, predicts the chained order, compares results.
module chain_order_checker
    import scp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [SEG_W-1:0]   s_tdata,   // start_x, start_y, end_x, end_y
    input  logic               s_tlast,   // last_in
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [SEG_W-1:0]   m_tdata,   // out_start_x, out_start_y, out_end_x, out_end_y
    input  logic               m_tlast,   // last_out
    input  logic [0:0]         m_tuser,   // overflow
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data,  // join_limit
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic signed [COORD_W-1:0] ey;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] sx;
    } segment_t;

    typedef struct {
        segment_t seg;
        logic     last;
        logic     ovf;
    } ordered_seg_t;

    segment_t           held_segs [MAX_SEGMENTS];
    int                 held_count;
    logic               dropped;
    logic [LIMIT_W-1:0] join_limit;
    ordered_seg_t       ordered_q [$];

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : model
        segment_t                  work [MAX_SEGMENTS];
        segment_t                  tmp;
        ordered_seg_t              got;
        ordered_seg_t              want;
        longint unsigned           lim;
        longint unsigned           d;
        longint                    dx;
        longint                    dy;
        int                        best;
        int                        bend;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
        if (!rst_n)
        begin
            held_count = 0;
            dropped    = 1'b0;
            join_limit = JOIN_LIMIT_RESET;
            ordered_q.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.seg  = segment_t'(m_tdata);
                got.last = m_tlast;
                got.ovf  = m_tuser[0];
                if (ordered_q.size() == 0)
                begin
                    $error("result with no expected item waiting: tdata %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = ordered_q.pop_front();
                    check_field("out_start_x", want.seg.sx, got.seg.sx);
                    check_field("out_start_y", want.seg.sy, got.seg.sy);
                    check_field("out_end_x", want.seg.ex, got.seg.ex);
                    check_field("out_end_y", want.seg.ey, got.seg.ey);
                    check_field("last_out", want.last, got.last);
                    check_field("overflow", want.ovf, got.ovf);
                end
            end

            if (cfg_valid && cfg_ready)
                join_limit = cfg_data;

            if (s_tvalid && s_tready)
            begin
                if (held_count < MAX_SEGMENTS)
                begin
                    held_segs[held_count] = segment_t'(s_tdata);
                    held_count++;
                end
                else
                    dropped = 1'b1;

                if (s_tlast)
                begin
                    for (int i = 0; i < held_count; i++)
                        work[i] = held_segs[i];
                    if (held_count >= MIN_CHAIN)
                    begin
                        for (int i = 0; i + 1 < held_count; i++)
                        begin
                            lim  = join_limit;
                            lim  = lim * lim;
                            best = i + 1;
                            bend = 0;
                            for (int j = i + 1; j < held_count; j++)
                            begin
                                for (int k = 0; k < 2; k++)
                                begin
                                    qx = (k == 0) ? work[j].sx : work[j].ex;
                                    qy = (k == 0) ? work[j].sy : work[j].ey;
                                    dx = longint'(work[i].ex) - longint'(qx);
                                    dy = longint'(work[i].ey) - longint'(qy);
                                    d  = dx * dx + dy * dy;
                                    // strict compare: ties keep the first candidate
                                    if (d < lim)
                                    begin
                                        lim  = d;
                                        best = j;
                                        bend = k;
                                    end
                                end
                            end
                            tmp         = work[i + 1];
                            work[i + 1] = work[best];
                            work[best]  = tmp;
                            if (bend != 0)
                            begin
                                tmp         = work[i + 1];
                                work[i + 1] = '{ey: tmp.sy, ex: tmp.sx, sy: tmp.ey, sx: tmp.ex};
                            end
                        end
                    end
                    for (int i = 0; i < held_count; i++)
                    begin
                        want.seg  = work[i];
                        want.last = (i == held_count - 1);
                        want.ovf  = dropped;
                        ordered_q.push_back(want);
                    end
                    held_count = 0;
                    dropped    = 1'b0;
                end
            end
            pending <= ordered_q.size();
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: drives segment lists and join_limit writes into the block and gives the verdict.
module tb_top;
    import scp_pkg::*;

    localparam int TOTAL_ITEMS     = 450;
    localparam int QUIET_FROM      = TOTAL_ITEMS - 60;
    localparam int LISTS_PER_PHASE = 5;
    localparam int SETTLE_CYCLES   = 16;
    localparam int DRAIN_CYCLES    = 32;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

    typedef enum int {
        PAT_FULL,
        PAT_GRID,
        PAT_CLUSTER
    } coord_pattern_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [SEG_W-1:0]   s_tdata   = '0;
    logic               s_tlast   = 1'b0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [SEG_W-1:0]   m_tdata;
    logic               m_tlast;
    logic [0:0]         m_tuser;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data  = '0;

    int   fail_count;
    int   pending;
    int   items_sent  = 0;
    int   idle_cycles = 0;
    logic quiet       = 1'b0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    segment_chain_ordering i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    chain_order_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic logic [SEG_W-1:0] seg_word(input int sx, sy, ex, ey);
        return {COORD_W'(ey), COORD_W'(ex), COORD_W'(sy), COORD_W'(sx)};
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input coord_pattern_t pat,
                                                       input int base, input int spread);
        int off;
        case (pat)
            PAT_FULL: return COORD_W'($urandom_range(0, 65535));
            PAT_GRID: return COORD_W'($urandom_range(0, 3) * 10);
            default:
            begin
                off = int'($urandom_range(0, 2 * spread)) - spread;
                return COORD_W'(base + off);
            end
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] next_limit(input int phase);
        case (phase % 8)
            0:       return '0;
            1:       return LIMIT_MAX;
            2:       return LIMIT_W'(1);
            3:       return LIMIT_W'($urandom_range(50, 3000));
            4:       return JOIN_LIMIT_RESET;
            5:       return LIMIT_W'($urandom_range(0, 131071));
            6:       return LIMIT_W'($urandom_range(3000, 40000));
            default: return LIMIT_W'($urandom_range(0, 300));
        endcase
    endfunction

    task automatic send_seg(input logic [SEG_W-1:0] data, input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (items_sent >= QUIET_FROM)
            quiet = 1'b1;
    endtask

    task automatic send_list(input int len);
        coord_pattern_t   pat;
        int               base_x;
        int               base_y;
        int               spread;
        int               sel;
        logic [COORD_W-1:0] c [4];
        sel = $urandom_range(0, 5);
        pat = (sel == 0) ? PAT_FULL : (sel == 1) ? PAT_GRID : PAT_CLUSTER;
        base_x = int'($urandom_range(0, 32000)) - 16000;
        base_y = int'($urandom_range(0, 32000)) - 16000;
        case ($urandom_range(0, 2))
            0:       spread = $urandom_range(0, 40);
            1:       spread = $urandom_range(40, 3000);
            default: spread = $urandom_range(3000, 16000);
        endcase
        for (int i = 0; i < len; i++)
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 14))
                    @(posedge clk);
            end
            for (int k = 0; k < 4; k++)
                c[k] = pick_coord(pat, (k % 2 == 0) ? base_x : base_y, spread);
            send_seg({c[3], c[2], c[1], c[0]}, i == len - 1);
        end
    endtask

    // only while the block is idle: all results out, then a settle pause
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : ready_gen
        logic hold;
        forever
        begin
            hold = quiet ? 1'b1 : ($urandom_range(0, 2) != 0);
            m_tready <= hold;
            repeat ($urandom_range(1, 14))
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase;
        int lists_in_phase;
        int sel;
        int len;
        phase          = 0;
        lists_in_phase = LISTS_PER_PHASE;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, short list, tie / reversal / out-of-reach, overflow with last on a dropped item
        send_seg(seg_word(-32768, 32767, 32767, -32768), 1'b1);
        send_list(3);
        send_seg(seg_word(0, 0, 100, 0), 1'b0);
        send_seg(seg_word(30000, 30000, 30000, 31000), 1'b0);
        send_seg(seg_word(300, 0, 200, 0), 1'b0);
        send_seg(seg_word(100, 100, 100, -100), 1'b1);
        send_list(17);

        while (items_sent < TOTAL_ITEMS)
        begin
            if (lists_in_phase == LISTS_PER_PHASE)
            begin
                write_limit(next_limit(phase));
                phase++;
                lists_in_phase = 0;
            end
            sel = $urandom_range(0, 9);
            if (sel == 0)
                len = $urandom_range(1, MIN_CHAIN - 1);
            else if (sel == 1)
                len = $urandom_range(MAX_SEGMENTS + 1, MAX_SEGMENTS + 4);
            else
                len = $urandom_range(MIN_CHAIN, MAX_SEGMENTS);
            send_list(len);
            lists_in_phase++;
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
